@@ rtl/core/sfcf_pkg.sv @@
// shared types, constants and helpers for the stereo feedback comb filter core
// no dependencies; used by the top level and sfcf_mac (sfcf_ring does not use it)
package sfcf_pkg;

    localparam int RING_DEPTH_DEF = 8192;
    localparam int TAG_BITS_DEF   = 16;

    localparam int SAMPLE_W  = 24;
    localparam int DELAY_W   = 21;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 1;

    // shared multiply-add operand and accumulator widths
    localparam int MAC_A_W = 25;
    localparam int MAC_B_W = 17;
    localparam int ACC_W   = 42;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 1'b1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [DELAY_W-1:0] DELAY_RESET  = 21'd256;
    localparam logic [GAIN_W-1:0]  GAIN_RESET   = 16'd0;
    localparam logic [GAIN_W-1:0]  FEEDBACK_MAX = 16'd55705;
    localparam int                 DELAY_MIN    = 256;

    // 0.55 and 0.45 in Q0.16
    localparam logic signed [MAC_B_W-1:0] MIX_DRY = 17'sd36045;
    localparam logic signed [MAC_B_W-1:0] MIX_WET = 17'sd29491;

    localparam logic signed [ACC_W-1:0] RND_8  = ACC_W'(128);
    localparam logic signed [ACC_W-1:0] RND_16 = ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-8388608);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRAP,
        S_RDA,
        S_RDB,
        S_DIFF,
        S_INTERP,
        S_FEED,
        S_WRITE,
        S_MIX,
        S_OUT
    } t_state;

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[SAMPLE_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[SAMPLE_W-1:0];
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/stereo_feedback_comb_filter_core.sv @@
// stereo feedback comb filter with fractional delay, top level
// depends on sfcf_pkg, sfcf_mac and sfcf_ring
//
// Two-channel feedback comb filter. A sample request (tuser opcode 0) goes from
// acceptance to a result in the output register by two ring reads through the
// single read port, then four passes through one shared multiply-add unit
// (interpolation, feedback, dry mix, wet mix). The next request is accepted
// once that result has been loaded, so one sample is in flight at a time; the
// load waits while the output register holds a result not yet taken. A clear
// request (opcode 1) gives no result. After reset the block clears all
// 2*2^clog2(RING_DEPTH) ring entries (16384 at the default depth) before it
// accepts its first request; configuration writes are taken at any time but
// must only be made while the block is idle.
module stereo_feedback_comb_filter_core #(
    parameter int RING_DEPTH = sfcf_pkg::RING_DEPTH_DEF,
    parameter int TAG_BITS   = sfcf_pkg::TAG_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sfcf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sfcf_pkg::DELAY_W-1:0]     i_cfg_data,
    // input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [sfcf_pkg::SAMPLE_W-1:0]    i_s_tdata,   // [23:0] in_sample
    input  logic [1:0]                       i_s_tuser,   // [0] opcode, [1] channel
    // output stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [sfcf_pkg::SAMPLE_W-1:0]    o_m_tdata    // [23:0] out_sample
);

    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int AW = IW + 1;
    localparam int PW = IW + 9;
    localparam int SW = sfcf_pkg::SAMPLE_W;
    localparam int MW = TAG_BITS + SW;
    localparam int ACW = sfcf_pkg::ACC_W;

    localparam logic [PW-1:0] TOTAL     = PW'(RING_DEPTH * 256);
    localparam logic [31:0]   MAX_DELAY = 32'((RING_DEPTH - 2) * 256);
    localparam logic [31:0]   MIN_DELAY = 32'(sfcf_pkg::DELAY_MIN);
    localparam logic [IW-1:0] LAST_IDX  = IW'(RING_DEPTH - 1);

    sfcf_pkg::t_state r_state, n_state;

    logic [sfcf_pkg::DELAY_W-1:0] r_delay_length;
    logic [sfcf_pkg::GAIN_W-1:0]  r_feedback_gain;
    logic [TAG_BITS-1:0]          r_gen;
    logic [IW-1:0]                r_widx [2];
    logic [AW-1:0]                r_clr_addr;
    logic                         r_out_valid;
    logic [SW-1:0]                r_out_data;

    // per-request working registers
    logic                         r_ch;
    logic signed [SW-1:0]         r_x;
    logic [PW-1:0]                r_pos;
    logic signed [SW-1:0]         r_a;
    logic signed [SW:0]           r_diff;
    logic signed [SW-1:0]         r_dly;
    logic signed [ACW-1:0]        r_acc;

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [MW-1:0] mem_rdata;

    // shared multiply-add
    logic signed [sfcf_pkg::MAC_A_W-1:0] mac_a;
    logic signed [sfcf_pkg::MAC_B_W-1:0] mac_b;
    logic signed [ACW-1:0]               mac_c;
    logic signed [ACW-1:0]               mac_acc;

    logic                      s_accept;
    logic                      out_load;
    logic [31:0]               dl_ext;
    logic [31:0]               d_eff32;
    logic [PW-1:0]             d_eff;
    logic [sfcf_pkg::GAIN_W-1:0] fb_eff;
    logic [PW-1:0]             pos_raw;
    logic [IW-1:0]             i0;
    logic [IW-1:0]             i1;
    logic [7:0]                frac;
    logic signed [SW-1:0]      rd_masked;
    logic signed [SW-1:0]      dly_now;
    logic signed [SW-1:0]      fed;
    logic signed [SW:0]        wr_sum;
    logic signed [SW-1:0]      wr_val;
    logic [IW-1:0]             w_cur;

    sfcf_ring #(
        .ADDR_W (AW),
        .DATA_W (MW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sfcf_mac u_mac (
        .i_a   (mac_a),
        .i_b   (mac_b),
        .i_c   (mac_c),
        .o_acc (mac_acc)
    );

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == sfcf_pkg::S_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // clamp configuration
    assign dl_ext  = 32'(r_delay_length);
    assign d_eff32 = (dl_ext < MIN_DELAY) ? MIN_DELAY :
                     ((dl_ext > MAX_DELAY) ? MAX_DELAY : dl_ext);
    assign d_eff   = d_eff32[PW-1:0];
    assign fb_eff  = (r_feedback_gain > sfcf_pkg::FEEDBACK_MAX) ?
                     sfcf_pkg::FEEDBACK_MAX : r_feedback_gain;

    // read point behind the write position, before wrapping
    assign pos_raw = {1'b0, r_widx[i_s_tuser[1]], 8'h00} + TOTAL - d_eff;

    assign i0   = r_pos[IW+7:8];
    assign i1   = (i0 == LAST_IDX) ? '0 : i0 + IW'(1);
    assign frac = r_pos[7:0];

    // stale generation reads as silence
    assign rd_masked = (mem_rdata[SW +: TAG_BITS] == r_gen) ? mem_rdata[SW-1:0] : '0;

    assign dly_now = r_acc[SW+7:8];
    assign fed     = r_acc[SW+15:16];
    assign wr_sum  = {r_x[SW-1], r_x} + {fed[SW-1], fed};
    assign wr_val  = sfcf_pkg::sat24(ACW'(wr_sum));
    assign w_cur   = r_widx[r_ch];

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = {r_ch, w_cur};
        mem_wdata = {r_gen, wr_val};
        mem_raddr = {r_ch, i0};
        mac_a     = sfcf_pkg::MAC_A_W'(r_diff);
        mac_b     = sfcf_pkg::MAC_B_W'({1'b0, frac});
        mac_c     = (ACW'(r_a) <<< 8) + sfcf_pkg::RND_8;
        out_load  = 1'b0;
        unique case (r_state)
            sfcf_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == '1) begin
                    n_state = sfcf_pkg::S_IDLE;
                end
            end
            sfcf_pkg::S_IDLE: begin
                if (s_accept && i_s_tuser[0] == sfcf_pkg::OP_SAMPLE) begin
                    n_state = sfcf_pkg::S_WRAP;
                end
            end
            sfcf_pkg::S_WRAP:   n_state = sfcf_pkg::S_RDA;
            sfcf_pkg::S_RDA:    n_state = sfcf_pkg::S_RDB;
            sfcf_pkg::S_RDB: begin
                mem_raddr = {r_ch, i1};
                n_state   = sfcf_pkg::S_DIFF;
            end
            sfcf_pkg::S_DIFF:   n_state = sfcf_pkg::S_INTERP;
            sfcf_pkg::S_INTERP: n_state = sfcf_pkg::S_FEED;
            sfcf_pkg::S_FEED: begin
                mac_a   = sfcf_pkg::MAC_A_W'(dly_now);
                mac_b   = sfcf_pkg::MAC_B_W'({1'b0, fb_eff});
                mac_c   = sfcf_pkg::RND_16;
                n_state = sfcf_pkg::S_WRITE;
            end
            sfcf_pkg::S_WRITE: begin
                mem_we  = 1'b1;
                mac_a   = sfcf_pkg::MAC_A_W'(r_x);
                mac_b   = sfcf_pkg::MIX_DRY;
                mac_c   = sfcf_pkg::RND_16;
                n_state = sfcf_pkg::S_MIX;
            end
            sfcf_pkg::S_MIX: begin
                mac_a   = sfcf_pkg::MAC_A_W'(r_dly);
                mac_b   = sfcf_pkg::MIX_WET;
                mac_c   = r_acc;
                n_state = sfcf_pkg::S_OUT;
            end
            sfcf_pkg::S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = sfcf_pkg::S_IDLE;
                end
            end
            default: n_state = sfcf_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= sfcf_pkg::S_CLEAR;
            r_clr_addr      <= '0;
            r_gen           <= TAG_BITS'(1);
            r_widx[0]       <= '0;
            r_widx[1]       <= '0;
            r_out_valid     <= 1'b0;
            r_delay_length  <= sfcf_pkg::DELAY_RESET;
            r_feedback_gain <= sfcf_pkg::GAIN_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == sfcf_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (s_accept && i_s_tuser[0] == sfcf_pkg::OP_CLEAR) begin
                r_gen     <= r_gen + TAG_BITS'(1);
                r_widx[0] <= '0;
                r_widx[1] <= '0;
            end
            if (r_state == sfcf_pkg::S_WRITE) begin
                r_widx[r_ch] <= (w_cur == LAST_IDX) ? '0 : w_cur + IW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sfcf_pkg::CFG_DELAY_LENGTH:  r_delay_length  <= i_cfg_data;
                    sfcf_pkg::CFG_FEEDBACK_GAIN: r_feedback_gain <= i_cfg_data[sfcf_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_ch  <= i_s_tuser[1];
            r_x   <= i_s_tdata;
            r_pos <= pos_raw;
        end
        case (r_state)
            sfcf_pkg::S_WRAP: begin
                if (r_pos >= TOTAL) begin
                    r_pos <= r_pos - TOTAL;
                end
            end
            sfcf_pkg::S_RDB:    r_a    <= rd_masked;
            sfcf_pkg::S_DIFF:   r_diff <= {rd_masked[SW-1], rd_masked} - {r_a[SW-1], r_a};
            sfcf_pkg::S_INTERP: r_acc  <= mac_acc;
            sfcf_pkg::S_FEED: begin
                r_dly <= dly_now;
                r_acc <= mac_acc;
            end
            sfcf_pkg::S_WRITE:  r_acc  <= mac_acc;
            sfcf_pkg::S_MIX:    r_acc  <= mac_acc;
            default: ;
        endcase
        if (out_load) begin
            r_out_data <= sfcf_pkg::sat24(r_acc >>> 16);
        end
    end

endmodule

@@ rtl/core/sfcf_mac.sv @@
// shared signed multiply-add unit: acc = c + a * b
// depends on sfcf_pkg for operand widths
module sfcf_mac (
    input  logic signed [sfcf_pkg::MAC_A_W-1:0] i_a,
    input  logic signed [sfcf_pkg::MAC_B_W-1:0] i_b,
    input  logic signed [sfcf_pkg::ACC_W-1:0]   i_c,
    output logic signed [sfcf_pkg::ACC_W-1:0]   o_acc
);

    logic signed [sfcf_pkg::MAC_A_W+sfcf_pkg::MAC_B_W-1:0] prod;

    assign prod  = i_a * i_b;
    assign o_acc = i_c + sfcf_pkg::ACC_W'(prod);

endmodule

@@ rtl/core/sfcf_ring.sv @@
// delay ring storage for both channels: one write port, one registered read port
// generic; no package dependency
module sfcf_ring #(
    parameter int ADDR_W = 14,
    parameter int DATA_W = 40
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
